// ----- hw/rtl/qph_pkg.sv -----
// shared constants and types for the quadratic probing hash insert core
package qph_pkg;

  // fixed field widths
  localparam int KEY_W       = 31;
  localparam int SLOT_W      = 10;
  localparam int CFG_W       = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 1;

  // serial divider step counter
  localparam int DIV_CNT_W = 5;

  // table size after reset
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1021;

  // occupancy table access request
  typedef struct packed {
    logic rd;
    logic wr_set;
  } occ_cmd_t;

endpackage

// ----- hw/rtl/qph_mod_div.sv -----
// serial restoring modulo unit, one key bit per cycle
module qph_mod_div #(
  parameter int SZ_W = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [qph_pkg::KEY_W-1:0] key,
  input  logic [SZ_W-1:0]           size,
  output logic                      done,
  output logic [SZ_W-1:0]           rem
);
  import qph_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0]     key_r;
  logic [SZ_W-1:0]      rem_r;
  logic [SZ_W:0]        trial;
  logic [SZ_W:0]        diff;
  logic [SZ_W-1:0]      rem_nxt;

  // shift in next key bit and subtract size when it fits
  always_comb begin
    trial   = {rem_r, key_r[KEY_W-1]};
    diff    = trial - {1'b0, size};
    rem_nxt = (trial >= {1'b0, size}) ? diff[SZ_W-1:0] : trial[SZ_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(KEY_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
      rem_r <= '0;
    end else if (busy_r) begin
      key_r <= key_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/qph_probe_gen.sv -----
// probe address sequencer: home + k*k mod size built from running odd steps
module qph_probe_gen #(
  parameter int SZ_W  = 11,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [IDX_W-1:0] home,
  input  logic [SZ_W-1:0]  size,
  output logic [IDX_W-1:0] addr,
  output logic             last
);
  import qph_pkg::*;

  localparam int W1 = SZ_W + 1;

  logic [IDX_W-1:0] p_r;
  logic [IDX_W-1:0] d_r;
  logic [SZ_W-1:0]  left_r;
  logic [W1-1:0]    size_x;
  logic [W1-1:0]    psum;
  logic [W1-1:0]    dsum;
  logic [W1-1:0]    dsum1;
  logic [W1-1:0]    p_nxt;
  logic [W1-1:0]    d_nxt;

  // next probe offset and next odd increment, both reduced mod size
  always_comb begin
    size_x = W1'(size);
    psum   = W1'(p_r) + W1'(d_r);
    p_nxt  = (psum >= size_x) ? psum - size_x : psum;
    dsum   = W1'(d_r) + W1'(2);
    dsum1  = (dsum >= size_x) ? dsum - size_x : dsum;
    // a size of one needs a second subtract
    d_nxt  = (dsum1 >= size_x) ? dsum1 - size_x : dsum1;
  end

  // probe state
  always_ff @(posedge clk) begin
    if (load) begin
      p_r    <= home;
      d_r    <= (size == SZ_W'(1)) ? '0 : IDX_W'(1);
      left_r <= (size >> 1) + SZ_W'(2);
    end else if (step) begin
      p_r    <= p_nxt[IDX_W-1:0];
      d_r    <= d_nxt[IDX_W-1:0];
      left_r <= left_r - 1'b1;
    end
  end

  assign addr = p_r;
  assign last = (left_r == SZ_W'(1));

endmodule

// ----- hw/rtl/qph_occ_table.sv -----
// occupancy bit memory with clearing sweep after reset
module qph_occ_table #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qph_pkg::occ_cmd_t cmd,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  output logic              rd_data,
  output logic              clr_busy
);
  import qph_pkg::*;

  logic             mem [DEPTH];
  logic             rd_data_r;
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= 1'b0;
    end else if (cmd.wr_set) begin
      mem[wr_addr] <= 1'b1;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ----- hw/rtl/quadratic_probe_hash_insert_core.sv -----
// top level of the quadratic probing hash insert core
// Inserts one 31-bit key per request into an open-addressed table of
// TABLE_DEPTH occupancy bits held in a synchronous memory with one write
// port and a registered read. The home slot is key mod table_size, found
// by a serial divider; then one probe per cycle reads home + k*k mod
// table_size for k up to table_size/2+1, and the first free slot is marked
// and returned with placed=1 (placed=0 and slot 0 when none is free). A
// table size of zero answers with placed=0 and slot 0 without dividing or
// probing. After reset the table is cleared entry by entry, during which no
// request is taken. A finished result waits in an output register while
// the next request is accepted. table_size above TABLE_DEPTH acts as
// TABLE_DEPTH; writing it does not clear the table.
module quadratic_probe_hash_insert_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write: table_size
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qph_pkg::CFG_W-1:0]       cfg_data,
  // key request: in_tdata holds key [30:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [qph_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result: out_tdata holds slot [9:0]; out_tuser holds placed [0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [qph_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [qph_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import qph_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);
  localparam int XW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_PROBE  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] table_size_r;
  logic [SZ_W-1:0]  eff_size;
  logic             in_acc;

  logic             div_done;
  logic [SZ_W-1:0]  div_rem;

  logic             pg_load;
  logic             pg_step;
  logic [IDX_W-1:0] pg_addr;
  logic             pg_last;

  occ_cmd_t         occ_cmd;
  logic             occ_rd_data;
  logic             clr_busy;

  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r;
  logic             pend_last_r;
  logic             issued_all_r, issued_all_nxt;
  logic             found;
  logic             miss_end;

  logic [IDX_W-1:0] res_addr_r, res_addr_nxt;
  logic             res_placed_r, res_placed_nxt;
  logic [XW-1:0]    res_wide;

  logic             out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic             out_placed_r;
  logic             out_load;

  // table size saturated to the depth
  always_comb begin
    if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      eff_size = SZ_W'(TABLE_DEPTH);
    end else begin
      eff_size = SZ_W'(table_size_r);
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
    end else if (cfg_valid) begin
      table_size_r <= cfg_data;
    end
  end

  assign in_tready = (state_r == S_IDLE) && !clr_busy;
  assign in_acc    = in_tvalid && in_tready;

  qph_mod_div #(
    .SZ_W (SZ_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (eff_size != '0)),
    .key   (in_tdata[KEY_W-1:0]),
    .size  (eff_size),
    .done  (div_done),
    .rem   (div_rem)
  );

  qph_probe_gen #(
    .SZ_W  (SZ_W),
    .IDX_W (IDX_W)
  ) u_probe (
    .clk  (clk),
    .load (pg_load),
    .step (pg_step),
    .home (div_rem[IDX_W-1:0]),
    .size (eff_size),
    .addr (pg_addr),
    .last (pg_last)
  );

  qph_occ_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (occ_cmd),
    .rd_addr  (pg_addr),
    .wr_addr  (pend_addr_r),
    .rd_data  (occ_rd_data),
    .clr_busy (clr_busy)
  );

  // probe results returning from the table
  assign found    = (state_r == S_PROBE) && pend_r && !occ_rd_data;
  assign miss_end = (state_r == S_PROBE) && pend_r && occ_rd_data && pend_last_r;

  // output register takes a result when empty or being drained
  assign out_load = (state_r == S_RESULT) && (!out_valid_r || out_tready);

  // control sequencing
  always_comb begin
    state_nxt      = state_r;
    pg_load        = 1'b0;
    pg_step        = 1'b0;
    occ_cmd        = '0;
    pend_nxt       = 1'b0;
    issued_all_nxt = issued_all_r;
    res_addr_nxt   = res_addr_r;
    res_placed_nxt = res_placed_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (eff_size == '0) begin
            res_addr_nxt   = '0;
            res_placed_nxt = 1'b0;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          pg_load        = 1'b1;
          issued_all_nxt = 1'b0;
          state_nxt      = S_PROBE;
        end
      end
      S_PROBE: begin
        if (found) begin
          occ_cmd.wr_set = 1'b1;
          res_addr_nxt   = pend_addr_r;
          res_placed_nxt = 1'b1;
          state_nxt      = S_RESULT;
        end else if (miss_end) begin
          res_addr_nxt   = '0;
          res_placed_nxt = 1'b0;
          state_nxt      = S_RESULT;
        end else if (!issued_all_r) begin
          // issue the next probe read
          occ_cmd.rd = 1'b1;
          pg_step    = 1'b1;
          pend_nxt   = 1'b1;
          if (pg_last) begin
            issued_all_nxt = 1'b1;
          end
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= 1'b0;
      issued_all_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      issued_all_r <= issued_all_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // in-flight probe and result payload
  always_ff @(posedge clk) begin
    if (pg_step) begin
      pend_addr_r <= pg_addr;
      pend_last_r <= pg_last;
    end
    res_addr_r   <= res_addr_nxt;
    res_placed_r <= res_placed_nxt;
  end

  // slot narrowed or widened to the output field
  assign res_wide = XW'(res_addr_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r   <= res_wide[SLOT_W-1:0];
      out_placed_r <= res_placed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_slot_r);
  assign out_tuser  = OUT_TUSER_W'(out_placed_r);

endmodule
